### rtl/otb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otb_pkg
// Shared sizes, request codes and types of the occupancy table.
// ----------------------------------------------------------------------------
package otb_pkg;

    // table geometry
    localparam int SLOTS      = 256;
    localparam int IDX_BITS   = $clog2(SLOTS);
    localparam int CNT_BITS   = $clog2(SLOTS + 1);
    localparam int VALUE_BITS = 32;

    // request codes carried on tuser
    typedef enum logic [1:0] {
        MODE_PUT  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_FIND = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    // table update issued by the control logic
    typedef struct packed {
        logic                  put;
        logic                  del;
        logic [IDX_BITS-1:0]   idx;
        logic [VALUE_BITS-1:0] value;
    } wr_req_t;

endpackage

### rtl/otb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otb_store
// Slot value memory with registered read, occupied bits and occupied count.
// ----------------------------------------------------------------------------
module otb_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  otb_pkg::wr_req_t              wr,
    input  logic                          rd_en,
    input  logic [otb_pkg::IDX_BITS-1:0]  rd_addr,
    output logic [otb_pkg::VALUE_BITS-1:0] rd_data,
    input  logic [otb_pkg::IDX_BITS-1:0]  chk_idx,
    output logic                          chk_occ,
    input  logic [otb_pkg::IDX_BITS-1:0]  cmp_idx,
    output logic                          cmp_occ,
    output logic [otb_pkg::CNT_BITS-1:0]  count
);
    import otb_pkg::*;

    logic [VALUE_BITS-1:0] mem [SLOTS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic [SLOTS-1:0]      occ_reg;
    logic [SLOTS-1:0]      occ_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;

    // value memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.put)
        begin
            mem[wr.idx] <= wr.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // occupied bits and count update
    always_comb
    begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (wr.put)
        begin
            occ_next[wr.idx] = 1'b1;
            count_next       = count_reg + CNT_BITS'(1);
        end
        else if (wr.del)
        begin
            occ_next[wr.idx] = 1'b0;
            count_next       = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign chk_occ = occ_reg[chk_idx];
    assign cmp_occ = occ_reg[cmp_idx];
    assign count   = count_reg;

endmodule

### rtl/occupancy_table_insert_delete_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_table_insert_delete_search
// Slot table with put, delete and lowest-index search by value.
// ----------------------------------------------------------------------------
// One request is handled at a time. Put, delete and the unused code give
// their result in the cycle after the request is taken. Find walks the slots
// from index 0 upward through the single read port of the value memory, one
// slot per cycle, and stops at the first occupied match or, when nothing
// matches, after the last slot. A new request is taken once the block is
// idle and the result register is empty or being drained in that cycle.
// Every result carries the occupied count after the request.
module occupancy_table_insert_delete_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // slot_index[7:0], item_value[39:8]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // stored[0], found[1], found_index[9:2],
                                   // element_count[18:10], out_of_range[19]
);
    import otb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic [CNT_BITS-1:0]   issue_cnt_reg, issue_cnt_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  stored_reg, stored_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   found_index_reg, found_index_next;
    logic [CNT_BITS-1:0]   element_count_reg, element_count_next;
    logic                  oor_reg, oor_next;

    wr_req_t               wr;
    logic                  rd_en;
    logic [VALUE_BITS-1:0] rd_data;
    logic                  chk_occ;
    logic                  cmp_occ;
    logic [CNT_BITS-1:0]   count;

    mode_t                 req_mode;
    logic [IDX_BITS-1:0]   req_idx;
    logic [VALUE_BITS-1:0] req_value;
    logic                  accept;
    logic                  req_oor;
    logic                  match;
    logic                  finish;

    // request fields
    assign req_mode  = mode_t'(s_tuser);
    assign req_idx   = s_tdata[IDX_BITS-1:0];
    assign req_value = s_tdata[IDX_BITS +: VALUE_BITS];

    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign req_oor  = ({1'b0, req_idx} >= CNT_BITS'(SLOTS));

    // scan read issue and compare stage
    assign rd_en  = (state_reg == ST_SCAN) && (issue_cnt_reg < CNT_BITS'(SLOTS));
    assign match  = (state_reg == ST_SCAN) && cmp_vld_reg && cmp_occ &&
                    (rd_data == key_reg);
    assign finish = (state_reg == ST_SCAN) && cmp_vld_reg &&
                    (match || (cmp_idx_reg == IDX_BITS'(SLOTS - 1)));

    otb_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (issue_cnt_reg[IDX_BITS-1:0]),
        .rd_data (rd_data),
        .chk_idx (req_idx),
        .chk_occ (chk_occ),
        .cmp_idx (cmp_idx_reg),
        .cmp_occ (cmp_occ),
        .count   (count)
    );

    // control and result logic
    always_comb
    begin
        state_next         = state_reg;
        key_next           = key_reg;
        issue_cnt_next     = issue_cnt_reg;
        cmp_vld_next       = rd_en && !finish;
        cmp_idx_next       = issue_cnt_reg[IDX_BITS-1:0];
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        stored_next        = stored_reg;
        found_next         = found_reg;
        found_index_next   = found_index_reg;
        element_count_next = element_count_reg;
        oor_next           = oor_reg;
        wr.put             = 1'b0;
        wr.del             = 1'b0;
        wr.idx             = req_idx;
        wr.value           = req_value;

        if (rd_en)
        begin
            issue_cnt_next = issue_cnt_reg + CNT_BITS'(1);
        end

        if (accept)
        begin
            stored_next        = 1'b0;
            found_next         = 1'b0;
            found_index_next   = '0;
            element_count_next = count;
            oor_next           = 1'b0;
            case (req_mode)
                MODE_PUT:
                begin
                    m_tvalid_next = 1'b1;
                    oor_next      = req_oor;
                    if (!req_oor && !chk_occ)
                    begin
                        wr.put             = 1'b1;
                        stored_next        = 1'b1;
                        element_count_next = count + CNT_BITS'(1);
                    end
                end
                MODE_DEL:
                begin
                    m_tvalid_next = 1'b1;
                    oor_next      = req_oor;
                    if (!req_oor && chk_occ)
                    begin
                        wr.del             = 1'b1;
                        element_count_next = count - CNT_BITS'(1);
                    end
                end
                MODE_FIND:
                begin
                    key_next       = req_value;
                    issue_cnt_next = '0;
                    state_next     = ST_SCAN;
                end
                default:
                begin
                    m_tvalid_next = 1'b1;
                end
            endcase
        end

        // end of search
        if (finish)
        begin
            state_next         = ST_IDLE;
            m_tvalid_next      = 1'b1;
            stored_next        = 1'b0;
            found_next         = match;
            found_index_next   = match ? cmp_idx_reg : '0;
            element_count_next = count;
            oor_next           = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg           <= key_next;
        cmp_idx_reg       <= cmp_idx_next;
        stored_reg        <= stored_next;
        found_reg         <= found_next;
        found_index_reg   <= found_index_next;
        element_count_reg <= element_count_next;
        oor_reg           <= oor_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, oor_reg, element_count_reg, found_index_reg,
                       found_reg, stored_reg};

endmodule

### tb/occupancy_table_insert_delete_search_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_table_insert_delete_search_test
// Self-checking bench for the slot table with put, delete and search.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream and results come back on the master
// stream. A copy of the table (values, occupied bits and count) is kept here
// and updated as each request is accepted, giving the result to expect. Each
// result is compared field by field with the oldest outstanding expectation.
// Named tests cover corner requests, a full fill and drain of the table, a
// long receiver hold-off and a large random mix of requests.
// ----------------------------------------------------------------------------
module occupancy_table_insert_delete_search_test;

    import otb_pkg::*;

    // result fields as unpacked from m_tdata
    typedef struct packed {
        logic                stored;
        logic                found;
        logic [IDX_BITS-1:0] found_index;
        logic [CNT_BITS-1:0] element_count;
        logic                out_of_range;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // slot_index[7:0], item_value[39:8]
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // stored[0], found[1], found_index[9:2],
                            // element_count[18:10], out_of_range[19]

    // shadow copy of the table
    logic [VALUE_BITS-1:0] shadow_values   [SLOTS];
    bit                    shadow_occupied [SLOTS];
    logic [CNT_BITS-1:0]   shadow_count;

    table_result_t         pending_results[$];
    int                    error_count;
    bit                    send_gaps_on;
    bit                    ready_gaps_on;
    bit                    hold_request;
    logic [VALUE_BITS-1:0] value_pool [8];

    occupancy_table_insert_delete_search dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // apply one request to the shadow table and return the result it gives
    function automatic table_result_t table_apply(mode_t mode, logic [IDX_BITS-1:0] idx,
                                                  logic [VALUE_BITS-1:0] value);
        table_result_t res;
        res = '0;
        case (mode)
            MODE_PUT:
            begin
                // idx is 8 bits wide, so it can never reach SLOTS here
                if (!shadow_occupied[idx])
                begin
                    shadow_values[idx]   = value;
                    shadow_occupied[idx] = 1'b1;
                    shadow_count         = shadow_count + CNT_BITS'(1);
                    res.stored           = 1'b1;
                end
            end
            MODE_DEL:
            begin
                if (shadow_occupied[idx])
                begin
                    shadow_occupied[idx] = 1'b0;
                    shadow_count         = shadow_count - CNT_BITS'(1);
                end
            end
            MODE_FIND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!res.found && shadow_occupied[i] && shadow_values[i] == value)
                    begin
                        res.found       = 1'b1;
                        res.found_index = IDX_BITS'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.element_count = shadow_count;
        return res;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // send one request, at times idling a random while first
    task automatic send_request(mode_t mode, logic [IDX_BITS-1:0] idx,
                                logic [VALUE_BITS-1:0] value);
        int gap;
        gap = 0;
        if (send_gaps_on && $urandom_range(0, 99) >= 55)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(table_apply(mode, idx, value));
    endtask

    task automatic report_mismatch(string field, int exp_val, int act_val);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, exp_val, act_val);
    endtask

    // result checker
    always @(posedge clk)
    begin
        table_result_t exp_res;
        table_result_t act_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            act_res.stored        = m_tdata[0];
            act_res.found         = m_tdata[1];
            act_res.found_index   = m_tdata[9:2];
            act_res.element_count = m_tdata[18:10];
            act_res.out_of_range  = m_tdata[19];
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result with none expected, actual %h", $time, m_tdata);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (act_res.stored !== exp_res.stored)
                    report_mismatch("stored", int'(exp_res.stored),
                                    int'(act_res.stored));
                if (act_res.found !== exp_res.found)
                    report_mismatch("found", int'(exp_res.found),
                                    int'(act_res.found));
                if (act_res.found_index !== exp_res.found_index)
                    report_mismatch("found_index", int'(exp_res.found_index),
                                    int'(act_res.found_index));
                if (act_res.element_count !== exp_res.element_count)
                    report_mismatch("element_count", int'(exp_res.element_count),
                                    int'(act_res.element_count));
                if (act_res.out_of_range !== exp_res.out_of_range)
                    report_mismatch("out_of_range", int'(exp_res.out_of_range),
                                    int'(act_res.out_of_range));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = 120;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (ready_gaps_on && $urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    // corner requests: slot and value extremes, every mode, duplicates, misses
    task automatic test_corners();
        send_request(MODE_FIND, 8'h00, 32'h0000_0000);      // find on empty table
        send_request(MODE_PUT,  8'h00, 32'h0000_0000);
        send_request(MODE_PUT,  8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_PUT,  8'h00, 32'h1234_5678);      // slot already taken
        send_request(MODE_PUT,  8'h80, 32'h8000_0000);
        send_request(MODE_FIND, 8'hAA, 32'h0000_0000);      // index field ignored
        send_request(MODE_FIND, 8'h55, 32'hFFFF_FFFF);      // match in the last slot
        send_request(MODE_FIND, 8'h00, 32'h5A5A_5A5A);      // no match, full walk
        send_request(MODE_PUT,  8'h07, 32'h0000_0000);      // duplicate value
        send_request(MODE_FIND, 8'h00, 32'h0000_0000);      // lowest of two matches
        send_request(MODE_DEL,  8'h00, 32'hFFFF_FFFF);
        send_request(MODE_FIND, 8'hFF, 32'h0000_0000);      // next match up
        send_request(MODE_DEL,  8'h00, 32'h0000_0000);      // delete of a free slot
        send_request(MODE_NOP,  8'hFF, 32'hFFFF_FFFF);
        send_request(MODE_NOP,  8'h00, 32'h0000_0000);
        send_request(MODE_PUT,  8'h00, 32'hA5A5_A5A5);      // reuse a freed slot
        send_request(MODE_FIND, 8'h00, 32'hA5A5_A5A5);
        send_request(MODE_DEL,  8'h07, 32'h0000_0000);
        send_request(MODE_DEL,  8'h80, 32'h0000_0000);
        send_request(MODE_DEL,  8'hFF, 32'h0000_0000);
        send_request(MODE_DEL,  8'h00, 32'h0000_0000);
        send_request(MODE_FIND, 8'h00, 32'hFFFF_FFFF);      // table empty again
    endtask

    // fill every slot, search the full table, then empty it
    task automatic test_fill_and_drain();
        int order [SLOTS];
        int pick;
        int swap_val;
        for (int i = 0; i < SLOTS; i++)
            order[i] = i;
        for (int i = SLOTS - 1; i > 0; i--)
        begin
            pick        = $urandom_range(0, i);
            swap_val    = order[i];
            order[i]    = order[pick];
            order[pick] = swap_val;
        end
        // fill at full rate on both sides
        send_gaps_on  = 1'b0;
        ready_gaps_on = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            send_request(MODE_PUT, IDX_BITS'(order[i]), 32'($urandom_range(0, 63)));
        send_gaps_on  = 1'b1;
        ready_gaps_on = 1'b1;
        send_request(MODE_PUT, 8'h00, 32'hFFFF_FFFF);       // table full
        send_request(MODE_PUT, 8'hFF, 32'h0000_0000);
        for (int i = 0; i < 24; i++)
            send_request(MODE_FIND, IDX_BITS'($urandom), 32'($urandom_range(0, 70)));
        for (int i = 0; i < SLOTS; i++)
            send_request(MODE_DEL, IDX_BITS'(order[SLOTS - 1 - i]), $urandom);
        send_request(MODE_DEL, 8'hFF, 32'h0000_0000);
    endtask

    // receiver holds off while requests keep coming
    task automatic test_back_pressure();
        send_gaps_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(MODE_PUT, IDX_BITS'($urandom_range(0, 7)), 32'($urandom_range(0, 3)));
        for (int i = 0; i < 6; i++)
            send_request(i % 2 ? MODE_FIND : MODE_DEL, IDX_BITS'($urandom_range(0, 7)),
                         32'($urandom_range(0, 3)));
        send_gaps_on = 1'b1;
    endtask

    // random mix, mostly over a small set of slots and values so requests collide
    task automatic test_random_mix(int count);
        mode_t                 mode;
        logic [IDX_BITS-1:0]   idx;
        logic [VALUE_BITS-1:0] value;
        int                    r;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom;
        for (int n = 0; n < count; n++)
        begin
            // a stretch with no idling on either side now and then
            if (n % 150 == 0)
            begin
                send_gaps_on  = (n % 300 != 0);
                ready_gaps_on = (n % 300 != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 35)
                mode = MODE_PUT;
            else if (r < 60)
                mode = MODE_DEL;
            else if (r < 95)
                mode = MODE_FIND;
            else
                mode = MODE_NOP;
            r = $urandom_range(0, 99);
            if (r < 60)
                idx = IDX_BITS'($urandom_range(0, 15));
            else if (r < 80)
                idx = IDX_BITS'($urandom_range(SLOTS - 16, SLOTS - 1));
            else
                idx = IDX_BITS'($urandom);
            if ($urandom_range(0, 99) < 70)
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom;
            send_request(mode, idx, value);
        end
    endtask

    // main sequence
    initial
    begin
        error_count   = 0;
        send_gaps_on  = 1'b1;
        ready_gaps_on = 1'b1;
        hold_request  = 1'b0;
        shadow_count  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_values[i]   = '0;
            shadow_occupied[i] = 1'b0;
        end
        rst_n    = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_PUT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_fill_and_drain();
        test_back_pressure();
        test_random_mix(560);

        // drain, then allow a full search time for anything stray
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
